// ----- rtl/sco_pkg.sv -----
// Shared types, constants and the CORDIC arctangent table for the swept-circle outline block.
// No dependencies.
package sco_pkg;

    localparam int COORD_W     = 32;
    localparam int RADIUS_W    = 31;
    localparam int ANGLE_W     = 32;
    localparam int CORDIC_W    = 64;
    localparam int ZACC_W      = 34;
    localparam int OFFSET_W    = 34;
    localparam int TABLE_IDX_W = 6;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [ANGLE_W-1:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic signed [31:0] GAIN_Q30     = 32'sd652032874;

    typedef enum logic [1:0] {
        KIND_POINT     = 2'd0,
        KIND_SEGMENT   = 2'd1,
        KIND_CIRCLE    = 2'd2,
        KIND_TRAPEZOID = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CLS_SAME      = 2'd0,
        CLS_SEGMENT   = 2'd1,
        CLS_INSIDE    = 2'd2,
        CLS_TRAPEZOID = 2'd3
    } class_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic [RADIUS_W-1:0]       first_radius;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic [RADIUS_W-1:0]       second_radius;
    } in_t;

    typedef struct packed {
        kind_t                     shape_kind;
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic [RADIUS_W-1:0]       circle_radius;
        logic                      last;
    } res_t;

    typedef struct packed {
        class_t                    cls;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic [RADIUS_W-1:0]       r1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic [RADIUS_W-1:0]       r2;
        logic signed [COORD_W:0]   dx;
        logic signed [COORD_W:0]   dy;
        logic signed [RADIUS_W:0]  dr;
    } job_t;

    typedef struct packed {
        logic                       start;
        logic                       vect;
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic [ANGLE_W-1:0]         angle;
    } cordic_cmd_t;

    typedef struct packed {
        logic                       done;
        logic                       flip;
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic [ANGLE_W-1:0]         z;
    } cordic_res_t;

    function automatic logic [ANGLE_W-1:0] atan_entry(input logic [TABLE_IDX_W-1:0] idx);
        logic [ANGLE_W-1:0] v;
        case (idx)
            6'd0:  v = 32'h2000_0000;
            6'd1:  v = 32'h12E4_051E;
            6'd2:  v = 32'h09FB_385B;
            6'd3:  v = 32'h0511_11D4;
            6'd4:  v = 32'h028B_0D43;
            6'd5:  v = 32'h0145_D7E1;
            6'd6:  v = 32'h00A2_F61E;
            6'd7:  v = 32'h0051_7C55;
            6'd8:  v = 32'h0028_BE53;
            6'd9:  v = 32'h0014_5F2F;
            6'd10: v = 32'h000A_2F98;
            6'd11: v = 32'h0005_17CC;
            6'd12: v = 32'h0002_8BE6;
            6'd13: v = 32'h0001_45F3;
            6'd14: v = 32'h0000_A2FA;
            6'd15: v = 32'h0000_517D;
            6'd16: v = 32'h0000_28BE;
            6'd17: v = 32'h0000_145F;
            6'd18: v = 32'h0000_0A30;
            6'd19: v = 32'h0000_0518;
            6'd20: v = 32'h0000_028C;
            6'd21: v = 32'h0000_0146;
            6'd22: v = 32'h0000_00A3;
            6'd23: v = 32'h0000_0051;
            6'd24: v = 32'h0000_0029;
            6'd25: v = 32'h0000_0014;
            6'd26: v = 32'h0000_000A;
            6'd27: v = 32'h0000_0005;
            6'd28: v = 32'h0000_0003;
            6'd29: v = 32'h0000_0001;
            6'd30: v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [OFFSET_W:0] v);
        logic signed [OFFSET_W:0] hi;
        logic signed [OFFSET_W:0] lo;
        hi = 35'sd2147483647;
        lo = -35'sd2147483648;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

// ----- rtl/sco_front.sv -----
// Front part: accepts circle pairs, forms differences and squared distances, classifies the beat.
// Depends on sco_pkg.
module sco_front
    import sco_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic job_valid,
    input  logic job_ready,
    output job_t job
);

    logic                    v1_reg, v2_reg;
    in_t                     in1_reg;
    logic signed [COORD_W:0] dx1_reg, dy1_reg;
    logic signed [RADIUS_W:0] dr1_reg;
    logic                    same1_reg, zero1_reg;

    job_t                    base2_reg;
    logic                    same2_reg, zero2_reg;
    logic [65:0]             sx2_reg, sy2_reg;
    logic [63:0]             sr2_reg;

    logic                    adv1, adv2;
    logic [COORD_W:0]        ax, ay;
    logic [RADIUS_W:0]       adr;
    logic [65:0]             dist_sq;
    logic                    contained;

    assign adv2      = !v2_reg || job_ready;
    assign adv1      = !v1_reg || adv2;
    assign s_ready   = adv1;
    assign job_valid = v2_reg;

    always_comb begin
        ax = dx1_reg[COORD_W] ? COORD_W'(0) - dx1_reg : dx1_reg;
        ay = dy1_reg[COORD_W] ? COORD_W'(0) - dy1_reg : dy1_reg;
        adr = dr1_reg[RADIUS_W] ? RADIUS_W'(0) - dr1_reg : dr1_reg;
        dist_sq = sx2_reg + sy2_reg;
        contained = dist_sq <= 66'(sr2_reg);
        job = base2_reg;
        if (same2_reg) begin
            job.cls = CLS_SAME;
        end else if (zero2_reg) begin
            job.cls = CLS_SEGMENT;
        end else if (contained) begin
            job.cls = CLS_INSIDE;
        end else begin
            job.cls = CLS_TRAPEZOID;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid;
            if (adv2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            in1_reg   <= s_data;
            dx1_reg   <= 33'(s_data.second_x) - 33'(s_data.first_x);
            dy1_reg   <= 33'(s_data.second_y) - 33'(s_data.first_y);
            dr1_reg   <= $signed({1'b0, s_data.first_radius}) -
                         $signed({1'b0, s_data.second_radius});
            same1_reg <= (s_data.first_x == s_data.second_x) &&
                         (s_data.first_y == s_data.second_y);
            zero1_reg <= (s_data.first_radius == '0) && (s_data.second_radius == '0);
        end
        if (adv2) begin
            base2_reg.cls <= CLS_TRAPEZOID;
            base2_reg.x1  <= in1_reg.first_x;
            base2_reg.y1  <= in1_reg.first_y;
            base2_reg.r1  <= in1_reg.first_radius;
            base2_reg.x2  <= in1_reg.second_x;
            base2_reg.y2  <= in1_reg.second_y;
            base2_reg.r2  <= in1_reg.second_radius;
            base2_reg.dx  <= dx1_reg;
            base2_reg.dy  <= dy1_reg;
            base2_reg.dr  <= dr1_reg;
            same2_reg     <= same1_reg;
            zero2_reg     <= zero1_reg;
            sx2_reg       <= 66'(ax) * 66'(ax);
            sy2_reg       <= 66'(ay) * 66'(ay);
            sr2_reg       <= 64'(adr) * 64'(adr);
        end
    end

endmodule

// ----- rtl/sco_queue.sv -----
// Short job queue between the front and back parts.
// Depends on sco_pkg.
module sco_queue
    import sco_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    job_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [PW:0]   cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign push_ready = cnt_reg != (PW+1)'(QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_reg] <= push_data;
    end

endmodule

// ----- rtl/sco_cordic.sv -----
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on sco_pkg.
module sco_cordic
    import sco_pkg::*;
#(
    parameter int STAGES = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cordic_cmd_t cmd,
    output cordic_res_t res
);

    localparam int CW = (STAGES > 1) ? $clog2(STAGES) : 1;

    logic                       busy_reg, busy_next, done_reg, done_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       vect_reg, vect_next, flip_reg, flip_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next, y_reg, y_next, xs, ys;
    logic signed [ZACC_W-1:0]   z_reg, z_next, step;
    logic                       ccw, rot_flip;
    logic [ANGLE_W-1:0]         turned, folded;

    always_comb begin
        xs       = x_reg >>> cnt_reg;
        ys       = y_reg >>> cnt_reg;
        step     = $signed({2'b00, atan_entry(TABLE_IDX_W'(cnt_reg))});
        ccw      = vect_reg ? y_reg[CORDIC_W-1] : !z_reg[ZACC_W-1];
        turned   = cmd.angle + QUARTER_TURN;
        rot_flip = turned[ANGLE_W-1];
        folded   = rot_flip ? cmd.angle - HALF_TURN : cmd.angle;

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        vect_next = vect_reg;
        flip_next = flip_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;

        if (cmd.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            vect_next = cmd.vect;
            if (cmd.vect) begin
                flip_next = 1'b0;
                if (cmd.x < 0) begin
                    x_next = -cmd.x;
                    y_next = -cmd.y;
                    z_next = $signed({2'b00, HALF_TURN});
                end else begin
                    x_next = cmd.x;
                    y_next = cmd.y;
                    z_next = '0;
                end
            end else begin
                flip_next = rot_flip;
                x_next    = cmd.x;
                y_next    = '0;
                z_next    = $signed({{2{folded[ANGLE_W-1]}}, folded});
            end
        end else if (busy_reg) begin
            if (ccw) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - step;
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + step;
            end
            if (cnt_reg == CW'(STAGES - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        vect_reg <= vect_next;
        flip_reg <= flip_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    assign res.done = done_reg;
    assign res.flip = flip_reg;
    assign res.x    = x_reg;
    assign res.y    = y_reg;
    assign res.z    = z_reg[ANGLE_W-1:0];

endmodule

// ----- rtl/sco_back.sv -----
// Back part: emits special-case results and runs the tangent-trapezoid sequence
// (normalize, square root, two vectorings, six rotations). Depends on sco_pkg, sco_cordic.
module sco_back
    import sco_pkg::*;
#(
    parameter int CORDIC_STAGES = 24
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic job_valid,
    output logic job_ready,
    input  job_t job,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_data
);

    typedef enum logic [15:0] {
        ST_IDLE    = 16'b0000_0000_0000_0001,
        ST_SPECIAL = 16'b0000_0000_0000_0010,
        ST_SEG2    = 16'b0000_0000_0000_0100,
        ST_NORM    = 16'b0000_0000_0000_1000,
        ST_SQ_X    = 16'b0000_0000_0001_0000,
        ST_SQ_Y    = 16'b0000_0000_0010_0000,
        ST_SQ_R    = 16'b0000_0000_0100_0000,
        ST_ROOT    = 16'b0000_0000_1000_0000,
        ST_VT_GO   = 16'b0000_0001_0000_0000,
        ST_VT_WAIT = 16'b0000_0010_0000_0000,
        ST_VD_GO   = 16'b0000_0100_0000_0000,
        ST_VD_WAIT = 16'b0000_1000_0000_0000,
        ST_RT_MUL  = 16'b0001_0000_0000_0000,
        ST_RT_GO   = 16'b0010_0000_0000_0000,
        ST_RT_WAIT = 16'b0100_0000_0000_0000,
        ST_RT_OUT  = 16'b1000_0000_0000_0000
    } state_t;

    localparam logic [COORD_W:0]  NORM_HIGH  = 33'h0_4000_0000;
    localparam logic [COORD_W:0]  NORM_LOW   = 33'h0_2000_0000;
    localparam logic [63:0]       ROOT_START = 64'h4000_0000_0000_0000;
    localparam logic signed [63:0] ROUND_HALF = 64'sh0000_0000_2000_0000;
    localparam logic [2:0]        ROT_LAST   = 3'd5;

    state_t                     state_reg, state_next;
    job_t                       job_reg, job_next;
    logic [COORD_W:0]           m_reg, m_next;
    logic signed [OFFSET_W-1:0] nx_reg, nx_next, ny_reg, ny_next, nr_reg, nr_next;
    logic signed [63:0]         acc_reg, acc_next;
    logic [63:0]                rem_reg, rem_next, res_reg, res_next, bit_reg, bit_next;
    logic [ANGLE_W-1:0]         theta_reg, theta_next, delta_reg, delta_next;
    logic [2:0]                 rot_reg, rot_next;
    logic signed [63:0]         prod_reg, prod_next;
    logic signed [OFFSET_W-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic                       out_valid_reg, out_valid_next;
    res_t                       out_reg, wr_data;
    logic                       wr, out_free;

    logic signed [31:0]         mul_a, mul_b;
    logic signed [63:0]         mul_p;
    logic [COORD_W:0]           ax, ay, adr, mx;
    logic [63:0]                trial;
    logic signed [63:0]         acc_sub, rx, ry;
    logic [ANGLE_W-1:0]         rot_ang;
    logic                       use_second;
    logic [RADIUS_W-1:0]        rot_r, big_r;
    logic signed [COORD_W-1:0]  cx, cy;
    cordic_cmd_t                cmd;
    cordic_res_t                cres;

    sco_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .res     (cres)
    );

    assign mul_p    = mul_a * mul_b;
    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    always_comb begin
        case (rot_reg)
            3'd0:    rot_ang = theta_reg + delta_reg;
            3'd1:    rot_ang = theta_reg;
            3'd2:    rot_ang = theta_reg - delta_reg;
            3'd3:    rot_ang = theta_reg - delta_reg;
            3'd4:    rot_ang = theta_reg + HALF_TURN;
            default: rot_ang = theta_reg + delta_reg;
        endcase
        use_second = rot_reg < 3'd3;
        rot_r = use_second ? job_reg.r2 : job_reg.r1;
        cx    = use_second ? job_reg.x2 : job_reg.x1;
        cy    = use_second ? job_reg.y2 : job_reg.y1;
        big_r = (job_reg.r1 >= job_reg.r2) ? job_reg.r1 : job_reg.r2;

        ax  = job.dx[COORD_W] ? COORD_W'(0) - job.dx : job.dx;
        ay  = job.dy[COORD_W] ? COORD_W'(0) - job.dy : job.dy;
        adr = job.dr[RADIUS_W] ? {1'b0, RADIUS_W'(0) - job.dr} : {1'b0, job.dr};
        mx  = (ax > ay) ? ax : ay;
        if (adr > mx) mx = adr;

        trial   = res_reg + bit_reg;
        acc_sub = acc_reg - mul_p;
        rx = cres.flip ? ROUND_HALF - cres.x : cres.x + ROUND_HALF;
        ry = cres.flip ? ROUND_HALF - cres.y : cres.y + ROUND_HALF;
    end

    always_comb begin
        state_next     = state_reg;
        job_next       = job_reg;
        m_next         = m_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        nr_next        = nr_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        theta_next     = theta_reg;
        delta_next     = delta_reg;
        rot_next       = rot_reg;
        prod_next      = prod_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        job_ready      = 1'b0;
        wr             = 1'b0;
        wr_data        = '0;
        cmd            = '0;
        mul_a          = nx_reg[31:0];
        mul_b          = nx_reg[31:0];

        unique case (state_reg)
            ST_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    job_next   = job;
                    m_next     = mx;
                    nx_next    = OFFSET_W'(job.dx);
                    ny_next    = OFFSET_W'(job.dy);
                    nr_next    = OFFSET_W'(job.dr);
                    state_next = (job.cls == CLS_TRAPEZOID) ? ST_NORM : ST_SPECIAL;
                end
            end
            ST_SPECIAL: begin
                if (out_free) begin
                    wr                 = 1'b1;
                    wr_data.shape_kind = KIND_CIRCLE;
                    wr_data.vertex_x   = job_reg.x1;
                    wr_data.vertex_y   = job_reg.y1;
                    wr_data.last       = 1'b1;
                    state_next         = ST_IDLE;
                    case (job_reg.cls)
                        CLS_SAME: begin
                            wr_data.circle_radius = big_r;
                            if (big_r == '0) wr_data.shape_kind = KIND_POINT;
                        end
                        CLS_SEGMENT: begin
                            wr_data.shape_kind = KIND_SEGMENT;
                            wr_data.last       = 1'b0;
                            state_next         = ST_SEG2;
                        end
                        default: begin
                            if (job_reg.r1 > job_reg.r2) begin
                                wr_data.circle_radius = job_reg.r1;
                            end else begin
                                wr_data.vertex_x      = job_reg.x2;
                                wr_data.vertex_y      = job_reg.y2;
                                wr_data.circle_radius = job_reg.r2;
                            end
                        end
                    endcase
                end
            end
            ST_SEG2: begin
                if (out_free) begin
                    wr                 = 1'b1;
                    wr_data.shape_kind = KIND_SEGMENT;
                    wr_data.vertex_x   = job_reg.x2;
                    wr_data.vertex_y   = job_reg.y2;
                    wr_data.last       = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            ST_NORM: begin
                if (m_reg >= NORM_HIGH) begin
                    m_next  = m_reg >> 1;
                    nx_next = nx_reg >>> 1;
                    ny_next = ny_reg >>> 1;
                    nr_next = nr_reg >>> 1;
                end else if (m_reg < NORM_LOW) begin
                    m_next  = m_reg << 1;
                    nx_next = nx_reg <<< 1;
                    ny_next = ny_reg <<< 1;
                    nr_next = nr_reg <<< 1;
                end else begin
                    state_next = ST_SQ_X;
                end
            end
            ST_SQ_X: begin
                acc_next   = mul_p;
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                mul_a      = ny_reg[31:0];
                mul_b      = ny_reg[31:0];
                acc_next   = acc_reg + mul_p;
                state_next = ST_SQ_R;
            end
            ST_SQ_R: begin
                mul_a      = nr_reg[31:0];
                mul_b      = nr_reg[31:0];
                rem_next   = acc_sub[63] ? '0 : acc_sub;
                res_next   = '0;
                bit_next   = ROOT_START;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (rem_reg >= trial) begin
                    rem_next = rem_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0]) state_next = ST_VT_GO;
            end
            ST_VT_GO: begin
                cmd.start  = 1'b1;
                cmd.vect   = 1'b1;
                cmd.x      = 64'(nx_reg);
                cmd.y      = 64'(ny_reg);
                state_next = ST_VT_WAIT;
            end
            ST_VT_WAIT: begin
                if (cres.done) begin
                    theta_next = cres.z;
                    state_next = ST_VD_GO;
                end
            end
            ST_VD_GO: begin
                cmd.start  = 1'b1;
                cmd.vect   = 1'b1;
                cmd.x      = 64'(nr_reg);
                cmd.y      = $signed(res_reg);
                state_next = ST_VD_WAIT;
            end
            ST_VD_WAIT: begin
                if (cres.done) begin
                    delta_next = cres.z;
                    rot_next   = '0;
                    state_next = ST_RT_MUL;
                end
            end
            ST_RT_MUL: begin
                mul_a      = $signed({1'b0, rot_r});
                mul_b      = GAIN_Q30;
                prod_next  = mul_p;
                state_next = ST_RT_GO;
            end
            ST_RT_GO: begin
                cmd.start  = 1'b1;
                cmd.x      = prod_reg;
                cmd.angle  = rot_ang;
                state_next = ST_RT_WAIT;
            end
            ST_RT_WAIT: begin
                if (cres.done) begin
                    ox_next    = OFFSET_W'(rx >>> 30);
                    oy_next    = OFFSET_W'(ry >>> 30);
                    state_next = ST_RT_OUT;
                end
            end
            ST_RT_OUT: begin
                if (out_free) begin
                    wr                 = 1'b1;
                    wr_data.shape_kind = KIND_TRAPEZOID;
                    wr_data.vertex_x   = sat_coord(35'(cx) + 35'(ox_reg));
                    wr_data.vertex_y   = sat_coord(35'(cy) + 35'(oy_reg));
                    wr_data.last       = rot_reg == ROT_LAST;
                    if (rot_reg == ROT_LAST) begin
                        state_next = ST_IDLE;
                    end else begin
                        rot_next   = rot_reg + 1'b1;
                        state_next = ST_RT_MUL;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (wr) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rot_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rot_reg       <= rot_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg   <= job_next;
        m_reg     <= m_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        nr_reg    <= nr_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        res_reg   <= res_next;
        bit_reg   <= bit_next;
        theta_reg <= theta_next;
        delta_reg <= delta_next;
        prod_reg  <= prod_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        if (wr) out_reg <= wr_data;
    end

`ifndef SYNTHESIS
    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        cres.done |-> (state_reg == ST_VT_WAIT || state_reg == ST_VD_WAIT ||
                       state_reg == ST_RT_WAIT))
        else $error("cordic result arrived with no consumer waiting");
    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SQ_X |-> (m_reg >= NORM_LOW && m_reg < NORM_HIGH))
        else $error("normalized magnitude out of range");
    a_root_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROOT |-> $onehot(bit_reg))
        else $error("square root trial bit lost");
    a_vertex_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr && wr_data.shape_kind == KIND_TRAPEZOID && wr_data.last) |-> rot_reg == ROT_LAST)
        else $error("trapezoid closed early");
`endif

endmodule

// ----- rtl/swept_circle_segment_outline.sv -----
// Swept-circle outline: front classifier, job queue, back sequencer with shared iterative CORDIC.
// The back part takes one job at a time: a point or circle job emits one beat, a segment two,
// and a trapezoid holds the back part through normalize, root, CORDIC and its six vertices.
// The front keeps accepting into a 4-entry queue while the back works.
// Reset: synchronous active-low aresetn clears all handshake and sequencer state; no clearing pass.
module swept_circle_segment_outline
    import sco_pkg::*;
#(
    parameter int CORDIC_STAGES = 24
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_data
);

    logic f_valid, f_ready, q_valid, q_ready;
    job_t f_job, q_job;

    sco_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    sco_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_job)
    );

    sco_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- bench/tb.sv -----
// Testbench for swept_circle_segment_outline: random and directed circle pairs are driven
// through the valid/ready input and every result beat is checked against a local predictor.
// Depends on sco_pkg and the swept_circle_segment_outline RTL.
`timescale 1ns / 1ps

module tb;
    import sco_pkg::*;

    localparam int STAGES = 24;
    localparam int CYCLE_LIMIT = 400000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    res_t m_data;

    swept_circle_segment_outline #(.CORDIC_STAGES(STAGES)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    in_t  pending_pairs[$];
    res_t expected_outline[$];
    int   error_count = 0;
    int   cycle_count = 0;
    bit   stimulus_done = 0;
    int   hold_off = 0;
    int   send_wait = 0;
    int   recv_wait = 0;

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    function automatic longint asr(longint v, int s);
        if (s > 63) s = 63;
        return v >>> s;
    endfunction

    function automatic logic [31:0] atan_turn(int i);
        logic [31:0] tab[31] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
            32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
            32'h00000001};
        if (i > 30) return 32'h0;
        return tab[i];
    endfunction

    function automatic logic [31:0] heading(longint x, longint y);
        logic [31:0] z;
        longint xs, ys;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = HALF_TURN;
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (y < 0) begin
                x -= ys; y += xs; z -= atan_turn(i);
            end else begin
                x += ys; y -= xs; z += atan_turn(i);
            end
        end
        return z;
    endfunction

    task automatic polar_offset(longint r, logic [31:0] ang, output longint ox,
                                output longint oy);
        bit flip;
        longint x, y, z, xs, ys;
        logic [31:0] sum;
        sum = ang + QUARTER_TURN;
        flip = sum >= HALF_TURN;
        if (flip) ang = ang - HALF_TURN;
        z = longint'($signed(ang));
        x = r * 64'sd652032874;
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(atan_turn(i));
            end else begin
                x += ys; y -= xs; z += longint'(atan_turn(i));
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        ox = asr(x + (64'sd1 <<< 29), 30);
        oy = asr(y + (64'sd1 <<< 29), 30);
    endtask

    function automatic logic [63:0] int_root(logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] clamp(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint scale2(longint v, int sh);
        return sh >= 0 ? v <<< sh : asr(v, -sh);
    endfunction

    task automatic push_beat(kind_t k, longint x, longint y, logic [30:0] rad, bit fin);
        res_t r;
        r.shape_kind = k;
        r.vertex_x = clamp(x);
        r.vertex_y = clamp(y);
        r.circle_radius = rad;
        r.last = fin;
        expected_outline.push_back(r);
    endtask

    task automatic predict_outline(in_t p);
        longint x1, y1, x2, y2, r1, r2, dx, dy, dr, nx, ny, nr, h2, ox, oy;
        logic [63:0] ax, ay, adr, s, sum, m;
        logic [31:0] theta, delta, ta, tb;
        int sh;
        x1 = p.first_x; y1 = p.first_y; x2 = p.second_x; y2 = p.second_y;
        r1 = p.first_radius; r2 = p.second_radius;
        sh = 0;
        if (x1 == x2 && y1 == y2) begin
            if (r1 >= r2) push_beat(r1 == 0 ? KIND_POINT : KIND_CIRCLE, x1, y1, r1, 1);
            else push_beat(KIND_CIRCLE, x1, y1, r2, 1);
            return;
        end
        if (r1 == 0 && r2 == 0) begin
            push_beat(KIND_SEGMENT, x1, y1, 0, 0);
            push_beat(KIND_SEGMENT, x2, y2, 0, 1);
            return;
        end
        dx = x2 - x1; dy = y2 - y1; dr = r1 - r2;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        adr = dr < 0 ? -dr : dr;
        s = ax * ax;
        sum = s + ay * ay;
        if (!(sum < s || sum > adr * adr)) begin
            if (r1 > r2) push_beat(KIND_CIRCLE, x1, y1, r1, 1);
            else push_beat(KIND_CIRCLE, x2, y2, r2, 1);
            return;
        end
        m = ax > ay ? ax : ay;
        if (adr > m) m = adr;
        while (m >= (64'd1 << 30)) begin
            m >>= 1; sh--;
        end
        while (m != 0 && m < (64'd1 << 29)) begin
            m <<= 1; sh++;
        end
        nx = scale2(dx, sh); ny = scale2(dy, sh); nr = scale2(dr, sh);
        h2 = nx * nx + ny * ny - nr * nr;
        if (h2 < 0) h2 = 0;
        theta = heading(nx, ny);
        delta = heading(nr, longint'(int_root(h2)));
        ta = theta + delta;
        tb = theta - delta;
        polar_offset(r2, ta, ox, oy);
        push_beat(KIND_TRAPEZOID, x2 + ox, y2 + oy, 0, 0);
        polar_offset(r2, theta, ox, oy);
        push_beat(KIND_TRAPEZOID, x2 + ox, y2 + oy, 0, 0);
        polar_offset(r2, tb, ox, oy);
        push_beat(KIND_TRAPEZOID, x2 + ox, y2 + oy, 0, 0);
        polar_offset(r1, tb, ox, oy);
        push_beat(KIND_TRAPEZOID, x1 + ox, y1 + oy, 0, 0);
        polar_offset(r1, theta + HALF_TURN, ox, oy);
        push_beat(KIND_TRAPEZOID, x1 + ox, y1 + oy, 0, 0);
        polar_offset(r1, ta, ox, oy);
        push_beat(KIND_TRAPEZOID, x1 + ox, y1 + oy, 0, 1);
    endtask

    task automatic report(string what, res_t got, res_t want);
        error_count++;
        $display("mismatch %s: got kind=%0d x=%0d y=%0d r=%0d last=%0d, want kind=%0d x=%0d y=%0d r=%0d last=%0d",
                 what, got.shape_kind, got.vertex_x, got.vertex_y, got.circle_radius, got.last,
                 want.shape_kind, want.vertex_x, want.vertex_y, want.circle_radius, want.last);
    endtask

    function automatic in_t pair(longint x1, longint y1, longint r1, longint x2, longint y2,
                                 longint r2);
        in_t p;
        p.first_x = x1; p.first_y = y1; p.first_radius = r1;
        p.second_x = x2; p.second_y = y2; p.second_radius = r2;
        return p;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 2000000) - 1000000;
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 255)
                                                 : 32'h80000000 + $urandom_range(0, 255);
        endcase
    endfunction

    function automatic logic [30:0] rand_radius();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return $urandom();
            2: return $urandom_range(0, 500000);
            default: return $urandom_range(0, 1) ? 31'h7FFFFFFF : 31'($urandom_range(1, 70000));
        endcase
    endfunction

    initial begin
        in_t p;
        pending_pairs.push_back(pair(0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(pair(100, -5, 65536, 100, -5, 131072));
        pending_pairs.push_back(pair(7, 7, 131072, 7, 7, 131072));
        pending_pairs.push_back(pair(-65536, 3, 0, 65536, 9, 0));
        pending_pairs.push_back(pair(32'sh80000000, 32'sh80000000, 0,
                                     32'sh7FFFFFFF, 32'sh7FFFFFFF, 0));
        pending_pairs.push_back(pair(0, 0, 655360, 65536, 0, 65536));
        pending_pairs.push_back(pair(0, 0, 65536, 65536, 0, 655360));
        pending_pairs.push_back(pair(0, 0, 131072, 65536, 0, 65536));
        pending_pairs.push_back(pair(0, 0, 65536, 655360, 0, 131072));
        pending_pairs.push_back(pair(0, 0, 131072, -655360, 655360, 65536));
        pending_pairs.push_back(pair(0, 0, 65536, 0, -655360, 65536));
        pending_pairs.push_back(pair(32'sh80000000, 32'sh80000000, 31'h7FFFFFFF,
                                     32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF));
        pending_pairs.push_back(pair(32'sh7FFFFFFF, 0, 31'h40000000, 32'sh80000000, 1, 1));
        pending_pairs.push_back(pair(-1, -1, 1, 1, 1, 0));
        pending_pairs.push_back(pair(0, 0, 0, 1, 0, 1));
        pending_pairs.push_back(pair(0, 0, 31'h7FFFFFFF, 5, 5, 31'h7FFFFFFF));
        for (int i = 0; i < 160; i++) begin
            p.first_x = rand_coord();
            p.first_y = rand_coord();
            p.first_radius = rand_radius();
            case ($urandom_range(0, 9))
                0: begin
                    p.second_x = p.first_x;
                    p.second_y = p.first_y;
                end
                1, 2, 3: begin
                    p.second_x = p.first_x + $urandom_range(0, 4000000) - 2000000;
                    p.second_y = p.first_y + $urandom_range(0, 4000000) - 2000000;
                end
                default: begin
                    p.second_x = rand_coord();
                    p.second_y = rand_coord();
                end
            endcase
            p.second_radius = $urandom_range(0, 7) == 0 ? 31'h0 : rand_radius();
            pending_pairs.push_back(p);
        end
    end

    initial begin
        aresetn = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
            s_data <= '0;
            send_wait <= $urandom_range(0, 13);
        end else if (s_valid && !s_ready) begin
            // hold
        end else begin
            if (s_valid && s_ready) predict_outline(s_data);
            if (pending_pairs.size() == 0) begin
                s_valid <= 0;
                stimulus_done <= !(s_valid && !s_ready);
            end else if (send_wait > 0 && !(cycle_count % 40 < 12)) begin
                s_valid <= 0;
                send_wait <= send_wait - 1;
            end else begin
                s_valid <= 1;
                s_data <= pending_pairs.pop_front();
                send_wait <= $urandom_range(0, 13);
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (!aresetn) begin
            m_ready <= 0;
            recv_wait <= 0;
            hold_off <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_outline.size() == 0) begin
                    report("unexpected beat", m_data, '0);
                end else begin
                    res_t want;
                    want = expected_outline.pop_front();
                    if (m_data.shape_kind !== want.shape_kind) report("shape_kind", m_data, want);
                    else if (m_data.vertex_x !== want.vertex_x) report("vertex_x", m_data, want);
                    else if (m_data.vertex_y !== want.vertex_y) report("vertex_y", m_data, want);
                    else if (m_data.circle_radius !== want.circle_radius)
                        report("circle_radius", m_data, want);
                    else if (m_data.last !== want.last) report("last", m_data, want);
                end
            end
            if (cycle_count == 200) begin
                hold_off <= 3000;
                m_ready <= 0;
            end else if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_ready <= 0;
            end else if (recv_wait > 0 && !(cycle_count % 50 < 15)) begin
                recv_wait <= recv_wait - 1;
                m_ready <= 0;
            end else begin
                m_ready <= 1;
                if (m_valid && m_ready) recv_wait <= $urandom_range(0, 13);
            end
        end
    end

    initial begin
        wait (stimulus_done && expected_outline.size() == 0);
        repeat (400) @(posedge aclk);
        if (error_count == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout");
        $display("FAILED: results differ");
        $finish;
    end

endmodule
